[design/assert_macros.svh]
// Assertion macros shared by the operating-time meter RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define OTM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define OTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OTM_ASSERT_NOW(lbl, ante, cons, msg)
`define OTM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/otm_pkg.sv]
// Package for the operating-time meter: request and result types, codes and
// selector decoding. Used by every module of the block; depends on nothing.
package otm_pkg;

    localparam int LED_CHANNELS_DEF = 6;
    localparam int MAX_CHANNELS     = 6;
    localparam int MS_W             = 10;
    localparam int SEC_W            = 32;
    localparam int SEL_W            = 4;
    localparam int PACK_W           = MAX_CHANNELS * MS_W;

    // One second in milliseconds, and two, at the width of a remainder sum.
    localparam logic [MS_W:0] MS_PER_SECOND = 11'd1000;
    localparam logic [MS_W:0] MS_TWO_SECONDS = 11'd2000;

    // Counter selector codes.
    localparam logic [SEL_W-1:0] SEL_COMP_BASE = 4'd6;
    localparam logic [SEL_W-1:0] SEL_SYSTEM    = 4'd12;
    localparam logic [SEL_W-1:0] SEL_NETWORK   = 4'd13;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_SET  = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]        kind;
        logic              in_network;
        logic [PACK_W-1:0] led_on_ms;
        logic [PACK_W-1:0] comp_on_ms;
        logic [SEL_W-1:0]  counter_sel;
        logic [SEC_W-1:0]  set_value;
    } t_otm_in;

    typedef struct packed {
        logic [SEC_W-1:0] read_value;
        logic             ok;
        logic             set_pending;
    } t_otm_out;

    // Per-lane control for one accumulator.
    typedef struct packed {
        logic tick;
        logic load;
    } t_lane_ctl;

    // A selector is valid for a fitted LED channel in either bank, or for
    // the system or network counter.
    function automatic logic sel_valid(input logic [SEL_W-1:0] sel,
                                       input logic [SEL_W-1:0] nch);
        logic plain_hit;
        logic comp_hit;
        plain_hit = (sel < nch);
        comp_hit  = (sel >= SEL_COMP_BASE) && (sel < (SEL_COMP_BASE + nch));
        return plain_hit || comp_hit || (sel == SEL_SYSTEM) || (sel == SEL_NETWORK);
    endfunction

endpackage

[design/otm_lane.sv]
// One accumulator lane: seconds counter plus millisecond remainder.
// Depends on otm_pkg.
module otm_lane (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  otm_pkg::t_lane_ctl      i_ctl,
    input  logic [otm_pkg::MS_W-1:0]  i_ms,
    input  logic [otm_pkg::SEC_W-1:0] i_load_value,
    output logic [otm_pkg::SEC_W-1:0] o_seconds
);
    import otm_pkg::*;

    logic [SEC_W-1:0] r_secs;
    logic [MS_W-1:0]  r_rem;
    logic [SEC_W-1:0] n_secs;
    logic [MS_W-1:0]  n_rem;
    logic [MS_W:0]    sum;
    logic [MS_W:0]    diff;
    logic [1:0]       carry;

    // Add this tick's milliseconds; up to two whole seconds can carry out.
    always_comb begin
        sum = {1'b0, r_rem} + {1'b0, i_ms};
        if (sum >= MS_TWO_SECONDS) begin
            carry = 2'd2;
            diff  = sum - MS_TWO_SECONDS;
        end else if (sum >= MS_PER_SECOND) begin
            carry = 2'd1;
            diff  = sum - MS_PER_SECOND;
        end else begin
            carry = 2'd0;
            diff  = sum;
        end
        n_rem = diff[MS_W-1:0];
        // A pending overwrite lands after the increment and wins.
        if (i_ctl.load) begin
            n_secs = i_load_value;
        end else begin
            n_secs = r_secs + {{(SEC_W-2){1'b0}}, carry};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secs <= '0;
            r_rem  <= '0;
        end else if (i_ctl.tick) begin
            r_secs <= n_secs;
            r_rem  <= n_rem;
        end
    end

    assign o_seconds = r_secs;

endmodule

[design/otm_merge.sv]
// Merging stage: picks the requested counter out of all lanes and holds the
// result in the output register. Depends on otm_pkg.
module otm_merge #(
    parameter int LED_CHANNELS = otm_pkg::LED_CHANNELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  logic [1:0]                i_kind,
    input  logic [otm_pkg::SEL_W-1:0] i_sel,
    input  logic                      i_pending,
    input  logic [otm_pkg::SEC_W-1:0] i_led_secs [LED_CHANNELS],
    input  logic [otm_pkg::SEC_W-1:0] i_comp_secs [LED_CHANNELS],
    input  logic [otm_pkg::SEC_W-1:0] i_sys_secs,
    input  logic [otm_pkg::SEC_W-1:0] i_net_secs,
    input  logic                      i_out_ready,
    output logic                      o_ready,
    output logic                      o_out_valid,
    output otm_pkg::t_otm_out         o_out
);
    import otm_pkg::*;

    localparam logic [SEL_W-1:0] NCH = SEL_W'(LED_CHANNELS);

    logic             r_valid;
    t_otm_out         r_out;
    t_otm_out         n_out;
    logic [SEC_W-1:0] counter;
    logic             valid_sel;

    // Select the addressed counter; lanes compare the selector in parallel.
    always_comb begin
        counter = '0;
        for (int i = 0; i < LED_CHANNELS; i++) begin
            if (i_sel == SEL_W'(i)) begin
                counter = i_led_secs[i];
            end
            if (i_sel == (SEL_COMP_BASE + SEL_W'(i))) begin
                counter = i_comp_secs[i];
            end
        end
        if (i_sel == SEL_SYSTEM) begin
            counter = i_sys_secs;
        end
        if (i_sel == SEL_NETWORK) begin
            counter = i_net_secs;
        end
    end

    assign valid_sel = sel_valid(i_sel, NCH);

    // Build the result for the accepted request.
    always_comb begin
        n_out             = '0;
        n_out.set_pending = i_pending;
        case (i_kind)
            KIND_TICK: begin
                n_out.ok = 1'b1;
            end
            KIND_SET: begin
                n_out.ok = valid_sel;
            end
            KIND_READ: begin
                n_out.ok = valid_sel;
                if (valid_sel) begin
                    n_out.read_value = counter;
                end
            end
            default: begin
                n_out.ok = 1'b0;
            end
        endcase
    end

    // Output register; a new request may enter whenever the held result leaves.
    assign o_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_take;
        end
        if (i_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

[design/operating_time_meter_unit.sv]
// Operating-time meter top level: system and network counters, the pending
// overwrite, one lane pair per LED channel, and the merging stage.
// Depends on otm_pkg, otm_lane, otm_merge and assert_macros.svh.
//
// The meter takes one request per clock cycle and returns exactly one result
// for each, in the cycle after acceptance, from a single output register. Every
// accumulator lane updates in the cycle its tick is accepted, so requests may
// follow each other without gaps; o_in_ready drops only while a held result
// is not taken. A tick adds one second to the system counter, one to the
// network counter when in network, and each channel's milliseconds to its
// plain and compensated accumulators. A set is held pending and overwrites
// its counter at the end of the next tick. All counters reset to zero.
`include "assert_macros.svh"

module operating_time_meter_unit #(
    parameter int LED_CHANNELS = otm_pkg::LED_CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  otm_pkg::t_otm_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output otm_pkg::t_otm_out o_out
);
    import otm_pkg::*;

    localparam logic [SEL_W-1:0] NCH = SEL_W'(LED_CHANNELS);

    logic             accept;
    logic             tick;
    logic             apply;
    logic             sys_load;
    logic             net_load;
    logic [SEC_W-1:0] sys_next;
    logic [SEC_W-1:0] net_next;
    logic             r_pending_flag;
    logic [SEL_W-1:0] r_pending_sel;
    logic [SEC_W-1:0] r_pending_value;
    logic             n_pending_flag;
    logic [SEL_W-1:0] n_pending_sel;
    logic [SEC_W-1:0] n_pending_value;
    logic [SEC_W-1:0] r_sys_secs;
    logic [SEC_W-1:0] r_net_secs;
    logic [SEC_W-1:0] led_secs [LED_CHANNELS];
    logic [SEC_W-1:0] comp_secs [LED_CHANNELS];

    assign accept = i_in_valid && o_in_ready;
    assign tick   = accept && (i_in.kind == KIND_TICK);
    assign apply  = tick && r_pending_flag;

    // Pending overwrite: a valid set replaces it, a tick consumes it.
    always_comb begin
        n_pending_flag  = r_pending_flag;
        n_pending_sel   = r_pending_sel;
        n_pending_value = r_pending_value;
        if (accept) begin
            case (i_in.kind)
                KIND_TICK: begin
                    n_pending_flag = 1'b0;
                end
                KIND_SET: begin
                    if (sel_valid(i_in.counter_sel, NCH)) begin
                        n_pending_flag  = 1'b1;
                        n_pending_sel   = i_in.counter_sel;
                        n_pending_value = i_in.set_value;
                    end
                end
                default: begin
                    n_pending_flag = r_pending_flag;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_flag  <= 1'b0;
            r_pending_sel   <= '0;
            r_pending_value <= '0;
        end else begin
            r_pending_flag  <= n_pending_flag;
            r_pending_sel   <= n_pending_sel;
            r_pending_value <= n_pending_value;
        end
    end

    // Overwrite targets and incremented values of the two plain counters.
    assign sys_load = apply && (r_pending_sel == SEL_SYSTEM);
    assign net_load = apply && (r_pending_sel == SEL_NETWORK);
    assign sys_next = r_sys_secs + SEC_W'(1);
    assign net_next = r_net_secs + SEC_W'(1);

    // System and network seconds; an overwrite lands after the increment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_secs <= '0;
            r_net_secs <= '0;
        end else if (tick) begin
            if (sys_load) begin
                r_sys_secs <= r_pending_value;
            end else begin
                r_sys_secs <= sys_next;
            end
            if (net_load) begin
                r_net_secs <= r_pending_value;
            end else if (i_in.in_network) begin
                r_net_secs <= net_next;
            end
        end
    end

    // One plain and one compensated lane per fitted LED channel.
    for (genvar g = 0; g < LED_CHANNELS; g++) begin : g_lane
        t_lane_ctl led_ctl;
        t_lane_ctl comp_ctl;

        assign led_ctl.tick  = tick;
        assign led_ctl.load  = apply && (r_pending_sel == SEL_W'(g));
        assign comp_ctl.tick = tick;
        assign comp_ctl.load = apply && (r_pending_sel == (SEL_COMP_BASE + SEL_W'(g)));

        otm_lane u_led (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (led_ctl),
            .i_ms         (i_in.led_on_ms[g*MS_W +: MS_W]),
            .i_load_value (r_pending_value),
            .o_seconds    (led_secs[g])
        );

        otm_lane u_comp (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (comp_ctl),
            .i_ms         (i_in.comp_on_ms[g*MS_W +: MS_W]),
            .i_load_value (r_pending_value),
            .o_seconds    (comp_secs[g])
        );
    end

    // Merge the lanes into the result register.
    otm_merge #(
        .LED_CHANNELS (LED_CHANNELS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (accept),
        .i_kind      (i_in.kind),
        .i_sel       (i_in.counter_sel),
        .i_pending   (n_pending_flag),
        .i_led_secs  (led_secs),
        .i_comp_secs (comp_secs),
        .i_sys_secs  (r_sys_secs),
        .i_net_secs  (r_net_secs),
        .i_out_ready (i_out_ready),
        .o_ready     (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // Checks on the block's own control.
    `OTM_ASSERT_NOW(a_stall_blocks, o_out_valid && !i_out_ready, !o_in_ready, "stalled but ready")
    `OTM_ASSERT_NEXT(a_result_follows, accept, o_out_valid, "accepted request gave no result")
    `OTM_ASSERT_NEXT(a_tick_clears, tick, !r_pending_flag, "pending set survived a tick")
    `OTM_ASSERT_NEXT(a_sys_count, tick && !sys_load, r_sys_secs == $past(sys_next), "tick lost")

endmodule

[dv/otm_tb_pkg.sv]
`timescale 1ns / 100ps
// Ledger class for the operating-time meter testbench: tracks every counter,
// predicts the result of each accepted request and checks the block's results.
// Depends on otm_pkg for the request and result types and the selector codes.
package otm_tb_pkg;
    import otm_pkg::*;

    // Kind code that the block must treat as a no-op.
    localparam logic [1:0] KIND_IDLE    = 2'd3;
    localparam int         NUM_COUNTERS = 14;

    class meter_ledger;
        int unsigned    nch;
        // Counters are kept at their selector index; each LED counter's
        // millisecond remainder sits at the same index.
        bit [SEC_W-1:0] seconds [NUM_COUNTERS];
        bit [MS_W-1:0]  remainder_ms [NUM_COUNTERS];
        bit             pend_flag;
        bit [SEL_W-1:0] pend_sel;
        bit [SEC_W-1:0] pend_value;
        t_otm_out       due_results [$];
        int unsigned    fail_count;

        function new(int unsigned channels);
            nch        = channels;
            pend_flag  = 1'b0;
            pend_sel   = '0;
            pend_value = '0;
            fail_count = 0;
            foreach (seconds[k]) begin
                seconds[k]      = '0;
                remainder_ms[k] = '0;
            end
        endfunction

        // A selector names a fitted LED channel in either bank, or the
        // system or network counter.
        function bit counter_exists(bit [SEL_W-1:0] sel);
            return (sel < nch) || (sel >= SEL_COMP_BASE && sel < SEL_COMP_BASE + nch) ||
                   (sel == SEL_SYSTEM) || (sel == SEL_NETWORK);
        endfunction

        // Adds one tick's on-time to a channel and carries whole seconds.
        function void add_on_time(int unsigned idx, bit [MS_W-1:0] ms);
            bit [MS_W:0] sum;
            sum               = remainder_ms[idx] + ms;
            seconds[idx]      = seconds[idx] + sum / MS_PER_SECOND;
            remainder_ms[idx] = sum % MS_PER_SECOND;
        endfunction

        // Updates the counters for an accepted request and queues its result.
        function void note_request(t_otm_in req);
            t_otm_out want;
            want = '0;
            case (req.kind)
                KIND_TICK: begin
                    seconds[SEL_SYSTEM] = seconds[SEL_SYSTEM] + 1;
                    if (req.in_network) begin
                        seconds[SEL_NETWORK] = seconds[SEL_NETWORK] + 1;
                    end
                    for (int i = 0; i < nch; i++) begin
                        add_on_time(i, req.led_on_ms[i*MS_W +: MS_W]);
                        add_on_time(int'(SEL_COMP_BASE) + i, req.comp_on_ms[i*MS_W +: MS_W]);
                    end
                    // The pending overwrite lands after this tick's increments.
                    if (pend_flag && counter_exists(pend_sel)) begin
                        seconds[pend_sel] = pend_value;
                    end
                    pend_flag = 1'b0;
                    want.ok   = 1'b1;
                end
                KIND_SET: begin
                    if (counter_exists(req.counter_sel)) begin
                        pend_sel   = req.counter_sel;
                        pend_value = req.set_value;
                        pend_flag  = 1'b1;
                        want.ok    = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (counter_exists(req.counter_sel)) begin
                        want.read_value = seconds[req.counter_sel];
                        want.ok         = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            want.set_pending = pend_flag;
            due_results.push_back(want);
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            // Keep the log readable once a broken block floods it.
            if (fail_count <= 100) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        // Compares a result from the block with the oldest prediction.
        task check_result(t_otm_out got);
            t_otm_out want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result with no request outstanding, value %h",
                                          got.read_value));
                return;
            end
            want = due_results.pop_front();
            if (got.read_value !== want.read_value) begin
                report_mismatch($sformatf("read_value got %h want %h",
                                          got.read_value, want.read_value));
            end
            if (got.ok !== want.ok) begin
                report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
            end
            if (got.set_pending !== want.set_pending) begin
                report_mismatch($sformatf("set_pending got %b want %b",
                                          got.set_pending, want.set_pending));
            end
        endtask
    endclass

endpackage

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top-level testbench for operating_time_meter_unit: directed and random
// requests under several idling phases, checked against meter_ledger.
// Depends on otm_pkg and otm_tb_pkg.
module testbench;
    import otm_pkg::*;
    import otm_tb_pkg::*;

    localparam int NCH              = LED_CHANNELS_DEF;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 48;
    localparam int TAIL_CYCLES      = 8;
    localparam int ITEMS_PER_PHASE  = 300;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_otm_in  i_in        = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_otm_out o_out;

    int unsigned tx_idle_pct    = 0;
    int unsigned rx_stall_pct   = 0;
    int unsigned hold_off_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned items_sent     = 0;
    meter_ledger ledger         = new(NCH);

    operating_time_meter_unit #(
        .LED_CHANNELS(NCH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // Clock with a 12 ns period.
    always #6 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Every result taken by the receiver is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            ledger.check_result(o_out);
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin : receiver
        int unsigned holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_count != holds_done) begin
                holds_done = hold_off_count;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Six on-times, each mostly uniform with some weight near both ends.
    function automatic logic [PACK_W-1:0] random_on_times();
        logic [PACK_W-1:0] pack;
        int unsigned       pick;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                pack[i*MS_W +: MS_W] = MS_W'($urandom_range(990, 1023));
            end else if (pick < 30) begin
                pack[i*MS_W +: MS_W] = MS_W'($urandom_range(0, 10));
            end else begin
                pack[i*MS_W +: MS_W] = MS_W'($urandom_range(0, 1023));
            end
        end
        return pack;
    endfunction

    // Set values lean toward the wrap point and toward zero.
    function automatic logic [SEC_W-1:0] random_seconds();
        case ($urandom_range(0, 3))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1:       return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Builds a request; fields the kind does not use get random content.
    function automatic t_otm_in make_request(input logic [1:0] kind,
                                             input logic [SEL_W-1:0] sel,
                                             input logic [SEC_W-1:0] value);
        t_otm_in req;
        req.kind        = kind;
        req.in_network  = 1'($urandom_range(0, 1));
        req.led_on_ms   = random_on_times();
        req.comp_on_ms  = random_on_times();
        req.counter_sel = sel;
        req.set_value   = value;
        return req;
    endfunction

    // A tick with the same on-time in every lane of both banks.
    function automatic t_otm_in even_tick(input logic in_net, input logic [MS_W-1:0] ms);
        t_otm_in req;
        req            = make_request(KIND_TICK, SEL_W'($urandom), $urandom);
        req.in_network = in_net;
        req.led_on_ms  = {MAX_CHANNELS{ms}};
        req.comp_on_ms = {MAX_CHANNELS{ms}};
        return req;
    endfunction

    // Offers one request after a random idle gap and waits for acceptance.
    // Valid stays high on return so back-to-back requests need no gap.
    task automatic send_request(input t_otm_in req);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ledger.note_request(req);
        if (req.kind != KIND_IDLE) begin
            items_sent++;
        end
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Extremes of the on-times, double carries, every kind and the selector
    // corner cases, in a fixed order.
    task automatic run_directed();
        send_request(make_request(KIND_READ, SEL_SYSTEM, $urandom));
        send_request(even_tick(1'b1, 10'd1023));
        send_request(even_tick(1'b1, 10'd1023));
        send_request(even_tick(1'b0, 10'd0));
        // Bring every remainder to 999, then carry two seconds at once.
        send_request(even_tick(1'b1, 10'd953));
        send_request(even_tick(1'b0, 10'd1023));
        send_request(make_request(KIND_READ, 4'd0, $urandom));
        send_request(make_request(KIND_READ, SEL_COMP_BASE, $urandom));
        send_request(make_request(KIND_READ, 4'd11, $urandom));
        send_request(make_request(KIND_READ, SEL_NETWORK, $urandom));
        // A read while a set waits sees the old value; a later set replaces
        // the pending one and a bad set leaves it alone.
        send_request(make_request(KIND_SET, 4'd0, 32'h1234_5678));
        send_request(make_request(KIND_READ, 4'd0, $urandom));
        send_request(make_request(KIND_SET, SEL_NETWORK, 32'hFFFF_FFFF));
        send_request(make_request(KIND_SET, 4'd15, $urandom));
        send_request(make_request(KIND_READ, 4'd14, $urandom));
        send_request(make_request(KIND_IDLE, SEL_NETWORK, $urandom));
        send_request(even_tick(1'b1, 10'd0));
        send_request(even_tick(1'b1, 10'd0));
        send_request(make_request(KIND_READ, SEL_NETWORK, $urandom));
        send_request(make_request(KIND_READ, 4'd0, $urandom));
        // Wrap an LED counter through a carry.
        send_request(make_request(KIND_SET, 4'd5, 32'hFFFF_FFFF));
        send_request(even_tick(1'b0, 10'd1023));
        send_request(even_tick(1'b0, 10'd1023));
        send_request(make_request(KIND_READ, 4'd5, $urandom));
    endtask

    // One random stretch: mostly ticks and reads, often a set followed by
    // the tick that applies it and a read back, with a little noise.
    task automatic random_episode();
        logic [SEL_W-1:0] sel;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        sel  = SEL_W'($urandom_range(0, 13));
        if (pick < 45) begin
            send_request(make_request(KIND_TICK, SEL_W'($urandom), $urandom));
        end else if (pick < 65) begin
            send_request(make_request(KIND_READ, SEL_W'($urandom_range(0, 15)), $urandom));
        end else if (pick < 90) begin
            send_request(make_request(KIND_SET, sel, random_seconds()));
            if ($urandom_range(0, 1) == 1) begin
                send_request(make_request(KIND_READ, sel, $urandom));
            end
            if ($urandom_range(0, 3) == 0) begin
                sel = SEL_W'($urandom_range(0, 13));
                send_request(make_request(KIND_SET, sel, random_seconds()));
            end
            if ($urandom_range(0, 3) == 0) begin
                send_request(make_request(KIND_SET, SEL_W'($urandom_range(14, 15)), $urandom));
            end
            send_request(make_request(KIND_TICK, SEL_W'($urandom), $urandom));
            send_request(make_request(KIND_READ, sel, $urandom));
        end else if (pick < 95) begin
            send_request(make_request(KIND_SET, SEL_W'($urandom_range(14, 15)), $urandom));
        end else begin
            send_request(make_request(KIND_IDLE, SEL_W'($urandom), $urandom));
        end
    endtask

    // Main sequence: reset, directed requests, then four idling phases.
    initial begin : stimulus
        int unsigned target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        wait_all_results();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    // Long receiver hold-off while requests keep coming.
                    hold_off_count <= hold_off_count + 1;
                end
                1: begin
                    tx_idle_pct  = 60;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 60;
                end
                default: begin
                    tx_idle_pct  = 27;
                    rx_stall_pct = 27;
                end
            endcase
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) random_episode();
            wait_all_results();
        end
        if (ledger.fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/otm_pkg.sv
design/otm_lane.sv
design/otm_merge.sv
design/operating_time_meter_unit.sv
dv/otm_tb_pkg.sv
dv/testbench.sv
